[src/ipd_pkg.sv]
`default_nettype none
package ipd_pkg;
    localparam int unsigned CoefWidth = 32;
    localparam int unsigned IdxWidth  = 4;
    localparam int unsigned StoreDepth = 16;

    localparam logic [1:0] STATUS_EXACT = 2'd0;
    localparam logic [1:0] STATUS_REM   = 2'd1;
    localparam logic [1:0] STATUS_BAD   = 2'd2;

    // Control from the sequencer to the cell row
    typedef struct packed {
        logic                 load;      // write one coefficient pair
        logic [IdxWidth-1:0]  load_idx;
        logic [CoefWidth-1:0] load_a;
        logic [CoefWidth-1:0] load_b;
        logic                 sub;       // subtract divisor times q at base
        logic [IdxWidth-1:0]  base;
        logic [IdxWidth-1:0]  m_deg;
        logic [CoefWidth-1:0] q;
    } ipd_ctrl_t;
endpackage
`default_nettype wire

[src/ipd_cell.sv]
`default_nettype none
module ipd_cell #(
    parameter int unsigned MY_IDX = 0
) (
    input  wire logic                          aclk,
    input  wire ipd_pkg::ipd_ctrl_t            ctrl,
    input  wire logic [ipd_pkg::CoefWidth-1:0] div_in,   // divisor at my_idx-base
    output logic      [ipd_pkg::CoefWidth-1:0] rem_out,
    output logic      [ipd_pkg::CoefWidth-1:0] dvs_out
);
    import ipd_pkg::*;

    logic [CoefWidth-1:0] rem_reg;
    logic [CoefWidth-1:0] dvs_reg;
    logic [CoefWidth-1:0] rem_next;
    logic [CoefWidth-1:0] prod;
    logic                 in_span;
    logic [IdxWidth:0]    top;

    // Cell is touched when base <= my index <= base + m
    always_comb begin
        top     = {1'b0, ctrl.base} + {1'b0, ctrl.m_deg};
        in_span = (IdxWidth'(MY_IDX) >= ctrl.base) &&
                  ((IdxWidth+1)'(MY_IDX) <= top);
        prod    = div_in * ctrl.q;
        rem_next = rem_reg - prod;
    end

    // Hold one working coefficient and one divisor coefficient
    always_ff @(posedge aclk) begin
        if (ctrl.load && ctrl.load_idx == IdxWidth'(MY_IDX)) begin
            rem_reg <= ctrl.load_a;
            dvs_reg <= ctrl.load_b;
        end else if (ctrl.sub && in_span) begin
            rem_reg <= rem_next;
        end
    end

    assign rem_out = rem_reg;
    assign dvs_out = dvs_reg;
endmodule
`default_nettype wire

[src/ipd_divider.sv]
`default_nettype none
module ipd_divider (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [ipd_pkg::CoefWidth-1:0] num,
    input  wire logic [ipd_pkg::CoefWidth-1:0] den,
    output logic                               done,
    output logic      [ipd_pkg::CoefWidth-1:0] quo
);
    import ipd_pkg::*;

    logic [CoefWidth-1:0] n_abs_reg, n_abs_next;
    logic [CoefWidth-1:0] d_abs_reg;
    logic [CoefWidth:0]   r_reg, r_next;
    logic [CoefWidth-1:0] q_reg, q_next;
    logic                 neg_reg;
    logic [5:0]           cnt_reg;
    logic                 busy_reg;
    logic [CoefWidth:0]   trial;

    // Restoring division, one quotient bit per cycle
    always_comb begin
        r_next     = {r_reg[CoefWidth-1:0], n_abs_reg[CoefWidth-1]};
        n_abs_next = {n_abs_reg[CoefWidth-2:0], 1'b0};
        trial      = r_next - {1'b0, d_abs_reg};
        q_next     = {q_reg[CoefWidth-2:0], ~trial[CoefWidth]};
        if (!trial[CoefWidth]) r_next = trial;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done <= 1'b0;
            if (start) begin
                busy_reg  <= 1'b1;
                cnt_reg   <= 6'(CoefWidth);
                n_abs_reg <= num[CoefWidth-1] ? -num : num;
                d_abs_reg <= den[CoefWidth-1] ? -den : den;
                neg_reg   <= num[CoefWidth-1] ^ den[CoefWidth-1];
                r_reg     <= '0;
                q_reg     <= '0;
            end else if (busy_reg) begin
                r_reg     <= r_next;
                n_abs_reg <= n_abs_next;
                q_reg     <= q_next;
                cnt_reg   <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1) begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

    assign quo = neg_reg ? -q_reg : q_reg;
endmodule
`default_nettype wire

[src/integer_polynomial_exact_divider.sv]
// Sequence: a bad divisor gives its one result the cycle after the last item; otherwise each
// quotient coefficient takes a start (ST_DIV), a bit-serial divide and capture (ST_WAIT) and
// a multiply-subtract (ST_SUB); a remainder scan (ST_CHECK) then precedes the first result.
// Throughput: one load item per cycle while s_tready is high; results one per cycle while
// m_tready is high; no item is taken after the last item until the final result is accepted.
// Reset: aresetn synchronous active low clears the sequencer; coefficient cells are not reset.
`default_nettype none
module integer_polynomial_exact_divider #(
    parameter int unsigned MAX_DEGREE = 15
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [3:0] coef_index, [35:4] dividend_coef, [67:36] divisor_coef,
    // [71:68] dividend_degree, [75:72] divisor_degree
    input  wire logic [79:0] s_tdata,
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [31:0] quotient_coef, [35:32] quotient_index, [37:36] status
    output logic [39:0]      m_tdata,
    output logic             m_tlast
);
    import ipd_pkg::*;

    localparam int unsigned NCell = (MAX_DEGREE + 1 < StoreDepth) ?
                                    MAX_DEGREE + 1 : StoreDepth;

    localparam logic [2:0] ST_LOAD  = 3'd0;
    localparam logic [2:0] ST_DIV   = 3'd1;
    localparam logic [2:0] ST_WAIT  = 3'd2;
    localparam logic [2:0] ST_SUB   = 3'd3;
    localparam logic [2:0] ST_CHECK = 3'd4;
    localparam logic [2:0] ST_EMIT  = 3'd5;

    logic [2:0]           state_reg;
    logic [IdxWidth-1:0]  n_reg, m_reg, i_reg, k_reg, chk_reg;
    logic                 nz_reg;
    logic [CoefWidth-1:0] q_reg;
    logic [CoefWidth-1:0] quot_mem [StoreDepth];
    ipd_ctrl_t            ctrl;
    logic [CoefWidth-1:0] rem_w [StoreDepth];
    logic [CoefWidth-1:0] dvs_w [StoreDepth];
    logic [CoefWidth-1:0] div_sel [StoreDepth];
    logic                 dv_start, dv_done;
    logic [CoefWidth-1:0] dv_quo;
    logic                 acc;
    logic [IdxWidth-1:0]  in_idx, in_n, in_m;
    logic [CoefWidth-1:0] in_lead;
    logic                 in_bad;
    logic                 out_fire;

    assign in_idx = s_tdata[3:0];
    assign in_n   = s_tdata[71:68];
    assign in_m   = s_tdata[75:72];
    assign acc    = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_LOAD);
    assign out_fire = m_tvalid && m_tready;
    // Leading divisor coefficient, taking the one loaded by this item if it lands there
    assign in_lead = (ctrl.load && in_idx == in_m) ? s_tdata[67:36] : dvs_w[in_m];
    assign in_bad = (32'(in_n) > MAX_DEGREE) || (32'(in_m) > MAX_DEGREE) ||
                    (in_m > in_n) || (in_lead == '0);

    // Row of cells, each holding one dividend and one divisor coefficient
    always_comb begin
        ctrl          = '0;
        ctrl.load     = acc && (32'(in_idx) <= MAX_DEGREE);
        ctrl.load_idx = in_idx;
        ctrl.load_a   = s_tdata[35:4];
        ctrl.load_b   = s_tdata[67:36];
        ctrl.sub      = (state_reg == ST_SUB);
        ctrl.base     = i_reg - m_reg;
        ctrl.m_deg    = m_reg;
        ctrl.q        = q_reg;
    end

    for (genvar c = 0; c < StoreDepth; c++) begin : g_cell
        if (c < NCell) begin : g_on
            // Divisor coefficient aligned to this cell
            assign div_sel[c] = dvs_w[IdxWidth'(IdxWidth'(c) - ctrl.base)];
            ipd_cell #(.MY_IDX(c)) u_cell (
                .aclk   (aclk),
                .ctrl   (ctrl),
                .div_in (div_sel[c]),
                .rem_out(rem_w[c]),
                .dvs_out(dvs_w[c])
            );
        end else begin : g_off
            assign div_sel[c] = '0;
            assign rem_w[c]   = '0;
            assign dvs_w[c]   = '0;
        end
    end

    assign dv_start = (state_reg == ST_DIV);
    ipd_divider u_div (
        .aclk(aclk), .aresetn(aresetn), .start(dv_start),
        .num(rem_w[i_reg]), .den(dvs_w[m_reg]),
        .done(dv_done), .quo(dv_quo)
    );

    // Quotient store
    always_ff @(posedge aclk) begin
        if (dv_done) quot_mem[i_reg - m_reg] <= dv_quo;
    end

    // Sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            m_tvalid  <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_LOAD: begin
                    if (acc && s_tlast) begin
                        n_reg <= in_n;
                        m_reg <= in_m;
                        i_reg <= in_n;
                        if (in_bad) begin
                            m_tvalid  <= 1'b1;
                            m_tdata   <= {2'b0, STATUS_BAD, 4'd0, 32'd0};
                            m_tlast   <= 1'b1;
                            state_reg <= ST_EMIT;
                        end else begin
                            state_reg <= ST_DIV;
                        end
                    end
                end
                ST_DIV: state_reg <= ST_WAIT;
                ST_WAIT: begin
                    if (dv_done) begin
                        q_reg     <= dv_quo;
                        state_reg <= ST_SUB;
                    end
                end
                ST_SUB: begin
                    if (i_reg == m_reg) begin
                        chk_reg   <= '0;
                        nz_reg    <= 1'b0;
                        state_reg <= ST_CHECK;
                    end else begin
                        i_reg     <= i_reg - 1'b1;
                        state_reg <= ST_DIV;
                    end
                end
                ST_CHECK: begin
                    // Scan remainder one coefficient per cycle
                    nz_reg  <= nz_reg || (rem_w[chk_reg] != '0);
                    chk_reg <= chk_reg + 1'b1;
                    if (chk_reg == n_reg) begin
                        k_reg     <= '0;
                        m_tvalid  <= 1'b1;
                        m_tdata   <= {2'b0,
                                      (nz_reg || rem_w[chk_reg] != '0) ?
                                      STATUS_REM : STATUS_EXACT,
                                      4'd0, quot_mem[0]};
                        m_tlast   <= (n_reg == m_reg);
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (out_fire) begin
                        if (m_tlast) begin
                            m_tvalid  <= 1'b0;
                            state_reg <= ST_LOAD;
                        end else begin
                            k_reg   <= k_reg + 1'b1;
                            m_tdata <= {2'b0, m_tdata[37:36], k_reg + 1'b1,
                                        quot_mem[k_reg + 1'b1]};
                            m_tlast <= ((k_reg + 1'b1) == (n_reg - m_reg));
                        end
                    end
                end
                default: state_reg <= ST_LOAD;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_LOAD) |-> !s_tready) else $error("accept while busy");
    a_valid_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (state_reg == ST_EMIT)) else $error("valid outside emit");
    a_bad_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[37:36] == STATUS_BAD) |-> m_tlast)
        else $error("bad divisor not single");
`endif
endmodule
`default_nettype wire
